@@ design/fpba_pkg.sv @@
// Package for the fit-policy block allocator: sizes, codes, state type,
// and the controller/datapath command and status structs. No dependencies.
package fpba_pkg;
   localparam int MAX_BLOCKS   = 64;
   localparam int SLOT_W       = 6;
   localparam int IDX_W        = 7;
   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 32;
   localparam int ADDR_W       = 17;
   localparam int ENTRY_W      = 2 * ADDR_W + 1 + IDX_W;
   localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(MAX_BLOCKS);

   localparam logic [2:0] ST_REUSED = 3'd0;
   localparam logic [2:0] ST_GROWN  = 3'd1;
   localparam logic [2:0] ST_FREED  = 3'd2;
   localparam logic [2:0] ST_NULL   = 3'd3;
   localparam logic [2:0] ST_NOSPC  = 3'd4;
   localparam logic [2:0] ST_BADFRE = 3'd5;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   localparam logic CSR_FIT_MODE   = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_EVAL, S_PICK_RD, S_PICK_EVAL, S_GROW, S_GROW_LINK,
      S_FRD, S_FEVAL, S_FNXT_RD, S_FNXT_EVAL, S_FPRV_RD, S_FPRV_EVAL, S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rd_cur;
      logic       rd_pick;
      logic       rd_nxt;
      logic       rd_prev;
      logic       eval;
      logic       pick_eval;
      logic       grow;
      logic       grow_link;
      logic       feval;
      logic       fnxt_eval;
      logic       fprv_eval;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic       is_free_op;
      logic       is_null;
      logic       scan_end;
      logic       hit_now;
      logic       pass2;
      logic       has_pick;
      logic       found;
      logic       nxt_ok;
      logic       prev_ok;
   } sts_type;

   typedef struct packed {
      logic [ADDR_W-1:0] len;
      logic              free;
      logic [IDX_W-1:0]  link;
      logic [ADDR_W-1:0] off;
   } entry_type;
endpackage

@@ design/fpba_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module fpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

@@ design/fpba_ctrl.sv @@
// Controller of the fit-policy block allocator: sequences list walks.
// Depends on fpba_pkg.
module fpba_ctrl import fpba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_RD;
         S_RD: begin
            if (sts.is_null) state_in = S_DONE;
            else if (sts.scan_end && !sts.pass2 && !sts.is_free_op) state_in = S_RD;
            else if (sts.scan_end)
               state_in = sts.is_free_op ? S_DONE
                        : (sts.has_pick ? S_PICK_RD : S_GROW);
            else state_in = sts.is_free_op ? S_FEVAL : S_EVAL;
         end
         S_EVAL: state_in = sts.hit_now ? S_PICK_RD : S_RD;
         S_PICK_RD: state_in = S_PICK_EVAL;
         S_PICK_EVAL: state_in = S_DONE;
         S_GROW: state_in = sts.found ? S_GROW_LINK : S_DONE;
         S_GROW_LINK: state_in = S_DONE;
         S_FEVAL: state_in = sts.found ? S_FNXT_RD : S_RD;
         S_FNXT_RD: state_in = S_FNXT_EVAL;
         S_FNXT_EVAL: state_in = S_FPRV_RD;
         S_FPRV_RD: state_in = S_FPRV_EVAL;
         S_FPRV_EVAL: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:      cmd.load = start;
         S_RD:        cmd.rd_cur = 1'b1;
         S_EVAL:      cmd.eval = 1'b1;
         S_PICK_RD:   cmd.rd_pick = 1'b1;
         S_PICK_EVAL: cmd.pick_eval = 1'b1;
         S_GROW:      cmd.grow = 1'b1;
         S_GROW_LINK: cmd.grow_link = 1'b1;
         S_FEVAL:     cmd.feval = 1'b1;
         S_FNXT_RD:   cmd.rd_nxt = 1'b1;
         S_FNXT_EVAL: cmd.fnxt_eval = 1'b1;
         S_FPRV_RD:   cmd.rd_prev = 1'b1;
         S_FPRV_EVAL: cmd.fprv_eval = 1'b1;
         S_DONE:      cmd.done = 1'b1;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
   assign busy = (state_ff != S_IDLE);

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> !busy) else $error("done not followed by idle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_RD) else $error("load did not start walk");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one command");
endmodule

@@ design/fpba_dp.sv @@
// Datapath of the fit-policy block allocator: block table RAM, list
// registers, fit evaluation and result. Depends on fpba_pkg, fpba_ram.
module fpba_dp import fpba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic              csr_we,
   input  logic              csr_sel,
   input  logic [ADDR_W-1:0] csr_wdata,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_data_address,
   output logic [ADDR_W-1:0] rsp_granted_size,
   output logic [1:0]        rsp_merges
);
   logic [1:0]              fit_mode_ff;
   logic [ADDR_W-1:0]       heap_limit_ff;
   logic [MAX_BLOCKS-1:0]   in_use_ff;
   logic [IDX_W-1:0]        head_ff, tail_ff, resume_ff;
   logic [ADDR_W:0]         top_ff;
   logic                    func_ff;
   logic [ADDR_W-1:0]       need_ff, addr_ff;
   logic                    null_ff;
   logic [IDX_W-1:0]        cur_ff, prev_ff, pick_ff, start_ff;
   logic [ADDR_W-1:0]       gap_ff;
   logic                    has_pick_ff, pass2_ff, found_ff;
   logic [IDX_W:0]          steps_ff;
   logic [1:0]              merges_ff;
   logic [ADDR_W:0]         flen_ff;
   entry_type               curent_ff;
   logic                    rv_ff;
   logic [2:0]              rst_ff;
   logic [ADDR_W-1:0]       rda_ff, rgs_ff;
   logic [1:0]              rmg_ff;

   logic                    we;
   logic [SLOT_W-1:0]       waddr, raddr;
   entry_type               wdata, rd;
   logic [IDX_W-1:0]        rd_link;
   logic [ADDR_W:0]         need_in;
   logic [ADDR_W-1:0]       gap;
   logic                    fits;
   logic [IDX_W-1:0]        walk_idx, first_idx, nstart;
   logic                    any_free;
   logic [SLOT_W-1:0]       free_slot;
   logic [ADDR_W+1:0]       grow_end;
   logic [ADDR_W-1:0]       limit;
   logic [ADDR_W:0]         merged_len;

   fpba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rd));

   assign rd_link  = rd.link[IDX_W-1] ? NO_SLOT : rd.link;
   assign need_in  = ((ADDR_W+1)'(req_request_size - 1'b1) >> 2 << 2)
                     + (ADDR_W+1)'(4);
   assign gap      = rd.len - need_ff;
   assign fits     = rd.free && (rd.len >= need_ff);
   assign nstart   = (resume_ff[IDX_W-1] || !in_use_ff[resume_ff[SLOT_W-1:0]])
                     ? head_ff : resume_ff;
   assign first_idx = (fit_mode_ff == FIT_NEXT) ? nstart : head_ff;
   assign walk_idx = cur_ff;
   assign limit    = (heap_limit_ff < ADDR_W'(HEAP_BYTES)) ? heap_limit_ff
                     : ADDR_W'(HEAP_BYTES);
   assign grow_end = (ADDR_W+2)'(top_ff) + (ADDR_W+2)'(HEADER_BYTES)
                     + (ADDR_W+2)'(need_ff);
   assign merged_len = (ADDR_W+1)'(rd.len) + (ADDR_W+1)'(HEADER_BYTES) + flen_ff;

   always_comb begin
      any_free  = 1'b0;
      free_slot = '0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            any_free  = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      raddr = walk_idx[SLOT_W-1:0];
      if (cmd.rd_pick) raddr = pick_ff[SLOT_W-1:0];
      if (cmd.rd_nxt)  raddr = curent_ff.link[SLOT_W-1:0];
      if (cmd.rd_prev) raddr = prev_ff[SLOT_W-1:0];
      if (cmd.grow)    raddr = tail_ff[SLOT_W-1:0];
   end

   always_comb begin
      sts = '0;
      sts.is_free_op = func_ff;
      sts.is_null    = null_ff;
      sts.scan_end   = cur_ff[IDX_W-1] || steps_ff[IDX_W] ||
                       (pass2_ff && steps_ff != '0 && cur_ff == start_ff);
      sts.hit_now    = fits && (fit_mode_ff == FIT_FIRST || fit_mode_ff == FIT_NEXT);
      sts.pass2      = pass2_ff;
      sts.has_pick   = has_pick_ff;
      sts.found      = cmd.grow ? (any_free && grow_end <= (ADDR_W+2)'(limit))
                       : (ADDR_W+1)'(rd.off) + (ADDR_W+1)'(HEADER_BYTES) ==
                         (ADDR_W+1)'(addr_ff) && !rd.free;
   end

   always_comb begin
      we    = 1'b0;
      waddr = cur_ff[SLOT_W-1:0];
      wdata = rd;
      if (cmd.pick_eval) begin
         we = 1'b1; waddr = pick_ff[SLOT_W-1:0]; wdata.free = 1'b0;
      end
      if (cmd.grow && sts.found) begin
         we = 1'b1; waddr = free_slot;
         wdata.len = need_ff; wdata.free = 1'b0; wdata.link = NO_SLOT;
         wdata.off = top_ff[ADDR_W-1:0];
      end
      if (cmd.grow_link && !tail_ff[IDX_W-1]) begin
         we = 1'b1; waddr = tail_ff[SLOT_W-1:0]; wdata = rd;
         wdata.link = cur_ff;
      end
      if (cmd.feval && sts.found) begin
         we = 1'b1; wdata.free = 1'b1;
      end
      if (cmd.fnxt_eval) begin
         we = 1'b1; wdata = curent_ff; wdata.free = 1'b1;
         if (rd.free && !curent_ff.link[IDX_W-1]) begin
            wdata.len  = ADDR_W'(merged_len);
            wdata.link = rd_link;
         end
      end
      if (cmd.fprv_eval && !prev_ff[IDX_W-1] && rd.free) begin
         we = 1'b1; waddr = prev_ff[SLOT_W-1:0]; wdata = rd;
         wdata.len  = ADDR_W'(merged_len);
         wdata.link = curent_ff.link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= FIT_FIRST;
         heap_limit_ff <= ADDR_W'(HEAP_BYTES);
         in_use_ff     <= '0;
         head_ff       <= NO_SLOT;
         tail_ff       <= NO_SLOT;
         resume_ff     <= NO_SLOT;
         top_ff        <= '0;
         rv_ff         <= 1'b0;
      end else begin
         rv_ff <= cmd.done;
         if (csr_we) begin
            if (csr_sel == CSR_FIT_MODE) fit_mode_ff <= csr_wdata[1:0];
            else heap_limit_ff <= csr_wdata;
         end
         if (cmd.load) begin
            func_ff   <= req_func;
            need_ff   <= need_in[ADDR_W-1:0];
            addr_ff   <= req_block_address;
            null_ff   <= req_func ? (req_block_address == '0) : (req_request_size == '0);
            cur_ff    <= (req_func) ? head_ff : first_idx;
            start_ff  <= first_idx;
            prev_ff   <= NO_SLOT;
            pass2_ff  <= (fit_mode_ff != FIT_NEXT) || (first_idx == head_ff);
            has_pick_ff <= 1'b0;
            steps_ff  <= '0;
            merges_ff <= '0;
            rst_ff    <= (req_func ? (req_block_address == '0) : (req_request_size == '0))
                         ? ST_NULL : (req_func ? ST_BADFRE : ST_NOSPC);
            rda_ff    <= '0;
            rgs_ff    <= '0;
         end
         if (cmd.rd_cur && sts.scan_end && !null_ff && !pass2_ff && !func_ff) begin
            pass2_ff <= 1'b1;
            cur_ff   <= head_ff;
            steps_ff <= '0;
         end
         if (cmd.eval) begin
            curent_ff <= rd;
            if (fits && (!has_pick_ff || (fit_mode_ff == FIT_BEST && gap < gap_ff)
                  || (fit_mode_ff == FIT_WORST && gap > gap_ff)
                  || fit_mode_ff == FIT_FIRST || fit_mode_ff == FIT_NEXT)) begin
               pick_ff <= cur_ff; gap_ff <= gap; has_pick_ff <= 1'b1;
            end
            cur_ff   <= rd_link;
            steps_ff <= steps_ff + 1'b1;
         end
         if (cmd.pick_eval) begin
            resume_ff <= rd_link;
            rst_ff    <= ST_REUSED;
            rda_ff    <= rd.off + ADDR_W'(HEADER_BYTES);
            rgs_ff    <= rd.len;
         end
         if (cmd.grow && sts.found) begin
            in_use_ff[free_slot] <= 1'b1;
            cur_ff    <= {1'b0, free_slot};
            if (tail_ff[IDX_W-1]) head_ff <= {1'b0, free_slot};
            top_ff    <= grow_end[ADDR_W:0];
            resume_ff <= NO_SLOT;
            rst_ff    <= ST_GROWN;
            rda_ff    <= top_ff[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
            rgs_ff    <= need_ff;
         end
         if (cmd.grow_link) tail_ff <= cur_ff;
         if (cmd.feval) begin
            curent_ff <= {rd.len, rd.free, rd_link, rd.off};
            if (sts.found) begin
               rst_ff  <= ST_FREED;
               flen_ff <= (ADDR_W+1)'(rd.len);
            end else begin
               prev_ff  <= cur_ff;
               cur_ff   <= rd_link;
               steps_ff <= steps_ff + 1'b1;
            end
         end
         if (cmd.fnxt_eval) begin
            if (rd.free && !curent_ff.link[IDX_W-1]) begin
               in_use_ff[curent_ff.link[SLOT_W-1:0]] <= 1'b0;
               if (tail_ff == curent_ff.link) tail_ff <= cur_ff;
               if (resume_ff == curent_ff.link) resume_ff <= cur_ff;
               flen_ff <= merged_len;
               curent_ff.link <= rd_link;
               merges_ff <= merges_ff + 1'b1;
            end
         end
         if (cmd.fprv_eval) begin
            if (!prev_ff[IDX_W-1] && rd.free) begin
               in_use_ff[cur_ff[SLOT_W-1:0]] <= 1'b0;
               if (tail_ff == cur_ff) tail_ff <= prev_ff;
               if (resume_ff == cur_ff) resume_ff <= prev_ff;
               rgs_ff <= merged_len[ADDR_W-1:0];
               merges_ff <= merges_ff + 1'b1;
            end else begin
               rgs_ff <= flen_ff[ADDR_W-1:0];
            end
         end
         if (cmd.done) rmg_ff <= merges_ff;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_data_address = rda_ff;
   assign rsp_granted_size = rgs_ff;
   assign rsp_merges       = rmg_ff;

   a_grow_top: assert property (@(posedge clock) disable iff (reset)
      (cmd.grow && sts.found) |=> top_ff > $past(top_ff))
      else $error("heap top did not grow");
   a_rsp_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NULL) |-> rsp_data_address == '0)
      else $error("null item returned an address");
   a_merges: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FREED) |-> rsp_merges == '0)
      else $error("merges on non-free item");
endmodule

@@ design/fit_policy_block_allocator.sv @@
// Top level of the fit-policy block allocator.
// Depends on fpba_pkg, fpba_ctrl, fpba_dp.
//  channel | direction | handshake           | payload
//  req     | in        | start & !busy       | func, request_size, block_address
//  rsp     | out       | rsp_valid, 1 cycle  | status, data_address, granted_size, merges
//  csr     | in        | valid & ready       | index, data
// An item takes one RAM read and one compare per table entry walked, one more
// read where the walk runs out (one per pass where next fit wraps), then the
// finishing states and a done state before start is taken again.
// Reset clears list pointers, slot use bits, heap top, rsp_valid; resets the CSRs.
// The result strobe lasts one cycle; the receiver cannot stall it.
module fit_policy_block_allocator import fpba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_data_address,
   output logic [ADDR_W-1:0] rsp_granted_size,
   output logic [1:0]        rsp_merges,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   fpba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy));

   fpba_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_func), .req_request_size(req_request_size),
      .req_block_address(req_block_address),
      .csr_we(csr_valid), .csr_sel(csr_index), .csr_wdata(csr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_data_address(rsp_data_address), .rsp_granted_size(rsp_granted_size),
      .rsp_merges(rsp_merges));
endmodule
